@@ rtl/dfph_pkg.sv @@
// ----------------------------------------------------------------------------
// dfph_pkg: shared constants, types and functions
// Sizes of the label dividers, port widths and the global link rule of the
// dragonfly path hop counter.
// ----------------------------------------------------------------------------
package dfph_pkg;

    localparam int LABEL_BITS = 20;

    // Restoring division, a few quotient bits per pipeline stage.
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (LABEL_BITS + DIV_BPS - 1) / DIV_BPS;
    localparam int DIVW       = DIV_STAGES * DIV_BPS;

    localparam int HOP_STAGES = 3;
    localparam int PIPE_DEPTH = 2 * DIV_STAGES + HOP_STAGES;

    // Width for comparing a group number with a link range (router*H+H+1).
    localparam int PRODW = 11;
    localparam int CW    = ((LABEL_BITS > PRODW + 1) ? LABEL_BITS : PRODW + 1) + 1;

    localparam int IN_W  = ((3 * LABEL_BITS + 7) / 8) * 8;
    localparam int OUT_W = 24;

    localparam logic [1:0] CFG_TPR = 2'd0;
    localparam logic [1:0] CFG_RPG = 2'd1;
    localparam logic [1:0] CFG_GPR = 2'd2;

    typedef struct packed {
        logic [4:0]  dest_router;
        logic [13:0] dest_group;
        logic [1:0]  valiant_local_hops;
        logic [1:0]  min_local_hops;
    } t_result;

    // Router with link product prod = a*H reaches the group other. The flag up
    // is set when other lies above the router's own group.
    function automatic logic has_link(input logic [PRODW-1:0] prod, input logic up,
                                      input logic [4:0] h,
                                      input logic [LABEL_BITS-1:0] other);
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        logic [CW-1:0] oth;
        lo  = CW'(prod) + CW'(up);
        hi  = lo + CW'(h);
        oth = CW'(other);
        return (oth >= lo) && (oth < hi);
    endfunction

endpackage

@@ rtl/dfph_div.sv @@
// ----------------------------------------------------------------------------
// dfph_div: pipelined restoring divider
// Divides a label-wide value by a 6-bit divisor, four quotient bits per stage.
// The user must hold the divisor steady while work is in flight (unchecked).
// ----------------------------------------------------------------------------
module dfph_div (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [dfph_pkg::DIVW-1:0] i_dividend,
    input  logic [5:0]            i_divisor,
    output logic [dfph_pkg::DIVW-1:0] o_quotient,
    output logic [5:0]            o_remainder
);
    import dfph_pkg::*;

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    logic [DIVW-1:0] r_work [DIV_STAGES];
    logic [5:0]      r_rem  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DIVW-1:0] w_in;
        logic [5:0]      rm_in;
        logic [DIVW-1:0] n_work;
        logic [5:0]      n_rem;

        if (s == 0) begin : g_first
            assign w_in  = i_dividend;
            assign rm_in = '0;
        end else begin : g_next
            assign w_in  = r_work[s-1];
            assign rm_in = r_rem[s-1];
        end

        always_comb begin
            logic [6:0] v_trial;
            n_work = w_in;
            n_rem  = rm_in;
            for (int j = 0; j < DIV_BPS; j++) begin
                v_trial = {n_rem, n_work[DIVW-1]};
                if (v_trial >= {1'b0, i_divisor}) begin
                    n_rem  = 6'(v_trial - {1'b0, i_divisor});
                    n_work = {n_work[DIVW-2:0], 1'b1};
                end else begin
                    n_rem  = v_trial[5:0];
                    n_work = {n_work[DIVW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_work[s] <= n_work;
                r_rem[s]  <= n_rem;
            end
        end
    end

    assign o_quotient  = r_work[DIV_STAGES-1];
    assign o_remainder = r_rem[DIV_STAGES-1];

endmodule

@@ rtl/dfph_hops.sv @@
// ----------------------------------------------------------------------------
// dfph_hops: local hop counter
// Three stages: group compares and link products, link range checks, and the
// hop sums for the minimal and the Valiant path.
// ----------------------------------------------------------------------------
module dfph_hops (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [4:0]            i_h,
    input  logic [dfph_pkg::LABEL_BITS-1:0] i_sg,
    input  logic [dfph_pkg::LABEL_BITS-1:0] i_vg,
    input  logic [dfph_pkg::LABEL_BITS-1:0] i_dg,
    input  logic [5:0]            i_sa,
    input  logic [5:0]            i_va,
    input  logic [5:0]            i_da,
    output dfph_pkg::t_result     o_result
);
    import dfph_pkg::*;

    // Stage 1
    logic [LABEL_BITS-1:0] r1_sg, r1_vg, r1_dg;
    logic [PRODW-1:0]      r1_psa, r1_pva, r1_pda;
    logic                  r1_eq_sd, r1_eq_sv, r1_eq_vd;
    logic                  r1_gt_sd, r1_gt_sv, r1_gt_vd;
    logic                  r1_ne_sd, r1_ne_sv, r1_ne_vd;
    logic [5:0]            r1_da;

    // Stage 2
    logic                  r2_eq_sd, r2_eq_sv, r2_eq_vd;
    logic                  r2_ne_sd, r2_ne_sv, r2_ne_vd;
    logic                  r2_l_sd, r2_l_ds, r2_l_sv, r2_l_vd, r2_l_dv;
    logic [LABEL_BITS-1:0] r2_dg;
    logic [5:0]            r2_da;

    logic [1:0] n_min;
    logic [1:0] n_leg1;
    logic [1:0] n_leg2;
    t_result    r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sg    <= i_sg;
            r1_vg    <= i_vg;
            r1_dg    <= i_dg;
            r1_psa   <= PRODW'(PRODW'(i_sa) * PRODW'(i_h));
            r1_pva   <= PRODW'(PRODW'(i_va) * PRODW'(i_h));
            r1_pda   <= PRODW'(PRODW'(i_da) * PRODW'(i_h));
            r1_eq_sd <= (i_sg == i_dg);
            r1_eq_sv <= (i_sg == i_vg);
            r1_eq_vd <= (i_vg == i_dg);
            r1_gt_sd <= (i_sg > i_dg);
            r1_gt_sv <= (i_sg > i_vg);
            r1_gt_vd <= (i_vg > i_dg);
            r1_ne_sd <= (i_sa != i_da);
            r1_ne_sv <= (i_sa != i_va);
            r1_ne_vd <= (i_va != i_da);
            r1_da    <= i_da;
        end
    end

    // The far end of a leg looks back at the near group, so its up flag is
    // the near end's greater-than flag.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_eq_sd <= r1_eq_sd;
            r2_eq_sv <= r1_eq_sv;
            r2_eq_vd <= r1_eq_vd;
            r2_ne_sd <= r1_ne_sd;
            r2_ne_sv <= r1_ne_sv;
            r2_ne_vd <= r1_ne_vd;
            r2_l_sd  <= has_link(r1_psa, !r1_gt_sd, i_h, r1_dg);
            r2_l_ds  <= has_link(r1_pda, r1_gt_sd, i_h, r1_sg);
            r2_l_sv  <= has_link(r1_psa, !r1_gt_sv, i_h, r1_vg);
            r2_l_vd  <= has_link(r1_pva, !r1_gt_vd, i_h, r1_dg);
            r2_l_dv  <= has_link(r1_pda, r1_gt_vd, i_h, r1_vg);
            r2_dg    <= r1_dg;
            r2_da    <= r1_da;
        end
    end

    always_comb begin
        n_min  = r2_eq_sd ? {1'b0, r2_ne_sd}
                          : 2'({1'b0, !r2_l_sd} + {1'b0, !r2_l_ds});
        n_leg1 = r2_eq_sv ? {1'b0, r2_ne_sv} : {1'b0, !r2_l_sv};
        n_leg2 = r2_eq_vd ? {1'b0, r2_ne_vd}
                          : 2'({1'b0, !r2_l_vd} + {1'b0, !r2_l_dv});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.min_local_hops     <= n_min;
            r_res.valiant_local_hops <= 2'(n_leg1 + n_leg2);
            r_res.dest_group         <= 14'(r2_dg);
            r_res.dest_router        <= 5'(r2_da);
        end
    end

    assign o_result = r_res;

endmodule

@@ rtl/dragonfly_path_hop_count.sv @@
// ----------------------------------------------------------------------------
// dragonfly_path_hop_count: minimal and Valiant local hop counts
// Each request passes two chained 5-stage label dividers and the 3-stage
// hop counter. Throughput: one request per cycle unless the 2-entry output
// buffer is full; it keeps input open while one result waits. Reset restores
// the sizes 4, 8 and 4 and empties all.
// ----------------------------------------------------------------------------
module dragonfly_path_hop_count (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_addr,
    input  logic [5:0]            i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: source_label, valiant_label, dest_label (20 bits each), zero pad.
    input  logic [dfph_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: min_local_hops[1:0], valiant_local_hops[3:2], dest_group[17:4],
    // dest_router[22:18], zero pad.
    output logic [dfph_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import dfph_pkg::*;

    logic [5:0] r_tpr, r_rpg;
    logic [4:0] r_gpr;
    logic [5:0] w_p, w_a;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_en, w_push, w_pop;

    t_result    r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic [DIVW-1:0] w_q1 [3];
    logic [5:0]      w_r1 [3];
    logic [DIVW-1:0] w_q2 [3];
    logic [5:0]      w_r2 [3];
    t_result         w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr <= 6'd4;
            r_rpg <= 6'd8;
            r_gpr <= 5'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_TPR: r_tpr <= i_cfg_data;
                CFG_RPG: r_rpg <= i_cfg_data;
                CFG_GPR: r_gpr <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // A P or A size of zero behaves as one.
    assign w_p = (r_tpr == '0) ? 6'd1 : r_tpr;
    assign w_a = (r_rpg == '0) ? 6'd1 : r_rpg;

    // The whole pipeline moves unless the output buffer is full.
    assign w_en            = (r_cnt != 2'd2);
    assign o_s_axis_tready = w_en;
    assign w_push          = w_en && r_vld[PIPE_DEPTH-1];
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // Group = (label / P) / A and router = (label / P) % A.
    for (genvar k = 0; k < 3; k++) begin : g_label
        dfph_div u_div_p (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_dividend  (DIVW'(i_s_axis_tdata[k*LABEL_BITS +: LABEL_BITS])),
            .i_divisor   (w_p),
            .o_quotient  (w_q1[k]),
            .o_remainder (w_r1[k])
        );
        dfph_div u_div_a (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_dividend  (w_q1[k]),
            .i_divisor   (w_a),
            .o_quotient  (w_q2[k]),
            .o_remainder (w_r2[k])
        );
    end

    dfph_hops u_hops (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_h      (r_gpr),
        .i_sg     (LABEL_BITS'(w_q2[0])),
        .i_vg     (LABEL_BITS'(w_q2[1])),
        .i_dg     (LABEL_BITS'(w_q2[2])),
        .i_sa     (w_r2[0]),
        .i_va     (w_r2[1]),
        .i_da     (w_r2[2]),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = OUT_W'(r_buf[r_rp]);

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == 2'($past(r_cnt) + 2'd1))
        else $error("result lost on entry to the output buffer");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == 2'($past(r_cnt) - 2'd1))
        else $error("result repeated by the output buffer");

    a_min_hops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("minimal path hop count above two");
`endif

endmodule
